// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants of the frame bitmap allocator
// Holds the field widths, the operation and register codes, the controller
// states and the find-first helper that the allocator core uses.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Field widths fixed by the stream and configuration interfaces
    localparam int FRAME_W     = 13;
    localparam int OP_W        = 3;
    localparam int ADDRESS_W   = 25;
    localparam int PAGE_SHIFT  = 12;           // 4 KB frames
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;

    // Bitmap organisation
    localparam int BITS_PER_WORD  = 32;
    localparam int BIT_W          = $clog2(BITS_PER_WORD);
    localparam int WIDX_W         = FRAME_W - BIT_W;
    localparam int NUM_FRAMES_DEF = 8192;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;

    typedef logic [BITS_PER_WORD-1:0] word_t;
    typedef logic [FRAME_W-1:0]       frame_t;
    typedef logic [WIDX_W-1:0]        widx_t;
    typedef logic [BIT_W-1:0]         bidx_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_FRAME    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_ENABLE = 1'b1;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_MARK_USED = 3'd0,
        OP_MARK_FREE = 3'd1,
        OP_TEST      = 3'd2,
        OP_ALLOC     = 3'd3,
        OP_RESCAN    = 3'd4
    } op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Index of the lowest set bit; zero when none is set
    function automatic bidx_t find_first_set(input word_t vec);
        bidx_t idx;
        idx = '0;
        for (int i = BITS_PER_WORD - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/fba_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// fba_bitmap_ram: busy bitmap storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module fba_bitmap_ram
    import fba_pkg::*;
#(
    parameter int DEPTH  = NUM_FRAMES_DEF / BITS_PER_WORD,
    parameter int ADDR_W = $clog2(NUM_FRAMES_DEF / BITS_PER_WORD)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  word_t             wdata,
    input  logic [ADDR_W-1:0] raddr,
    output word_t             rdata
);

    word_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/frame_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core: next-fit allocator of 4 KB physical frames
// Keeps one busy bit per frame in a word-wide memory and a next-free hint.
// Serves mark used, mark free, test, allocate and rescan requests. With search
// on, allocate and rescan scan the bitmap one word per cycle for a free frame.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------------
//   s_*     | in        | s_tvalid/s_tready  | op, frame
//   m_*     | out       | m_tvalid/m_tready  | frame_busy, alloc_frame,
//           |           |                    | alloc_address, found, hint
//   cfg_*   | in        | cfg_we             | last_frame, search_enable
//
// One request is served at a time. Mark, test and unknown operations pass
// through the modify and done states to the result register. Allocate and
// rescan, when search is enabled, add a scan of the bitmap memory at one word
// per cycle through its single read port.
// After reset a clearing pass writes zero to every bitmap word before the
// first request is accepted. The result waits in an output register while
// m_tready is low; the next request is taken once the result is loaded.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core
    import fba_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // op[2:0], frame[15:3]

    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // frame_busy[0], alloc_frame[13:1],
                                              // alloc_address[38:14], found[39],
                                              // hint[52:40], zero[55:53]

    // Configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WORD_COUNT = (NUM_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // Request fields
    op_t    in_op;
    frame_t in_frame;

    // Control state
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    frame_t             hint_reg, hint_next;
    frame_t             last_frame_reg;
    logic               search_enable_reg;

    // Request in progress
    op_t    op_reg, op_next;
    frame_t frame_reg, frame_next;

    // Search sequencer
    widx_t  w_reg, w_next;
    logic   seg_reg, seg_next;
    logic   issue_more_reg, issue_more_next;
    logic   chk_valid_reg, chk_valid_next;
    widx_t  chk_word_reg, chk_word_next;
    logic   chk_seg_reg, chk_seg_next;

    // Result being built and the output register
    logic   res_busy_reg, res_busy_next;
    frame_t res_afr_reg, res_afr_next;
    logic   res_found_reg, res_found_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_busy_reg, out_busy_next;
    frame_t out_afr_reg, out_afr_next;
    logic   out_found_reg, out_found_next;
    frame_t out_hint_reg, out_hint_next;

    // Memory ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    word_t             mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    word_t             mem_rdata;

    // Derived datapath signals
    frame_t end_frame;
    logic   frame_in_range;
    bidx_t  frame_bit;
    word_t  frame_mask;
    frame_t lo_frame, hi_frame;
    word_t  eligible;
    word_t  free_vec;
    logic   hit;
    widx_t  seg_hi_word;
    logic   out_slot_free;

    assign in_op    = op_t'(s_tdata[OP_W-1:0]);
    assign in_frame = s_tdata[OP_W+FRAME_W-1:OP_W];

    // Bitmap memory
    fba_bitmap_ram #(
        .DEPTH  (WORD_COUNT),
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Search bounds and frame decode
    always_comb
    begin
        if (32'(last_frame_reg) > 32'(NUM_FRAMES - 1))
        begin
            end_frame = FRAME_W'(NUM_FRAMES - 1);
        end
        else
        begin
            end_frame = last_frame_reg;
        end
        frame_in_range = (32'(frame_reg) < 32'(NUM_FRAMES));
        frame_bit      = frame_reg[BIT_W-1:0];
        frame_mask     = word_t'(1) << frame_bit;
    end

    // Free-bit check of the word returned by the memory
    always_comb
    begin
        lo_frame = chk_seg_reg ? '0 : hint_reg;
        hi_frame = chk_seg_reg ? hint_reg : end_frame;
        for (int b = 0; b < BITS_PER_WORD; b++)
        begin
            eligible[b] = ((chk_word_reg > lo_frame[FRAME_W-1:BIT_W]) ||
                           (BIT_W'(b) >= lo_frame[BIT_W-1:0])) &&
                          ((chk_word_reg < hi_frame[FRAME_W-1:BIT_W]) ||
                           (BIT_W'(b) <= hi_frame[BIT_W-1:0]));
        end
        free_vec    = ~mem_rdata & eligible;
        hit         = chk_valid_reg && (free_vec != '0);
        seg_hi_word = seg_reg ? hint_reg[FRAME_W-1:BIT_W] : end_frame[FRAME_W-1:BIT_W];
    end

    assign out_slot_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(WORD_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if ((op_reg == OP_ALLOC || op_reg == OP_RESCAN) && search_enable_reg)
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                if (hit || (!chk_valid_reg && !issue_more_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller and datapath updates
    always_comb
    begin
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = ADDR_W'(frame_reg[FRAME_W-1:BIT_W]);
        mem_wdata       = mem_rdata;
        mem_raddr       = ADDR_W'(w_reg);
        clr_addr_next   = clr_addr_reg;
        hint_next       = hint_reg;
        op_next         = op_reg;
        frame_next      = frame_reg;
        w_next          = w_reg;
        seg_next        = seg_reg;
        issue_more_next = issue_more_reg;
        chk_valid_next  = 1'b0;
        chk_word_next   = w_reg;
        chk_seg_next    = seg_reg;
        res_busy_next   = res_busy_reg;
        res_afr_next    = res_afr_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_busy_next   = out_busy_reg;
        out_afr_next    = out_afr_reg;
        out_found_next  = out_found_reg;
        out_hint_next   = out_hint_reg;

        case (state_reg)
            // Clearing pass: one zero word per cycle
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end

            // Take a request and start reading the word it touches
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_op == OP_ALLOC)
                begin
                    mem_raddr = ADDR_W'(hint_reg[FRAME_W-1:BIT_W]);
                end
                else
                begin
                    mem_raddr = ADDR_W'(in_frame[FRAME_W-1:BIT_W]);
                end
                if (s_tvalid)
                begin
                    op_next    = in_op;
                    frame_next = (in_op == OP_ALLOC) ? hint_reg : in_frame;
                end
            end

            // Read-modify-write of the word and set-up of the search
            ST_MODIFY:
            begin
                res_busy_next  = 1'b0;
                res_afr_next   = '0;
                res_found_next = 1'b0;
                case (op_reg)
                    OP_MARK_USED:
                    begin
                        mem_we    = frame_in_range;
                        mem_wdata = mem_rdata | frame_mask;
                    end
                    OP_MARK_FREE:
                    begin
                        mem_we    = frame_in_range;
                        mem_wdata = mem_rdata & ~frame_mask;
                    end
                    OP_TEST:
                    begin
                        res_busy_next = frame_in_range && mem_rdata[frame_bit];
                    end
                    OP_ALLOC:
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = mem_rdata | frame_mask;
                        res_afr_next = frame_reg;
                    end
                    default:
                    begin
                    end
                endcase
                // The first pass is empty when the hint lies above the end
                issue_more_next = 1'b1;
                if (hint_reg > end_frame)
                begin
                    seg_next = 1'b1;
                    w_next   = '0;
                end
                else
                begin
                    seg_next = 1'b0;
                    w_next   = hint_reg[FRAME_W-1:BIT_W];
                end
            end

            // Word scan: issue one read and check the previous word each cycle
            ST_SEARCH:
            begin
                chk_valid_next = issue_more_reg;
                chk_word_next  = w_reg;
                chk_seg_next   = seg_reg;
                if (issue_more_reg)
                begin
                    if (w_reg == seg_hi_word)
                    begin
                        if (!seg_reg)
                        begin
                            seg_next = 1'b1;
                            w_next   = '0;
                        end
                        else
                        begin
                            issue_more_next = 1'b0;
                        end
                    end
                    else
                    begin
                        w_next = w_reg + WIDX_W'(1);
                    end
                end
                if (hit)
                begin
                    hint_next      = {chk_word_reg, find_first_set(free_vec)};
                    res_found_next = 1'b1;
                    chk_valid_next = 1'b0;
                end
            end

            // Hand the result to the output register
            ST_DONE:
            begin
                if (out_slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_busy_next  = res_busy_reg;
                    out_afr_next   = res_afr_reg;
                    out_found_next = res_found_reg;
                    out_hint_next  = hint_reg;
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            hint_reg       <= '0;
            issue_more_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            hint_reg       <= hint_next;
            issue_more_reg <= issue_more_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame_reg    <= '0;
            search_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LAST_FRAME)
            begin
                last_frame_reg <= cfg_data[FRAME_W-1:0];
            end
            if (cfg_index == REG_SEARCH_ENABLE)
            begin
                search_enable_reg <= cfg_data[0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        frame_reg     <= frame_next;
        w_reg         <= w_next;
        seg_reg       <= seg_next;
        chk_word_reg  <= chk_word_next;
        chk_seg_reg   <= chk_seg_next;
        res_busy_reg  <= res_busy_next;
        res_afr_reg   <= res_afr_next;
        res_found_reg <= res_found_next;
        out_busy_reg  <= out_busy_next;
        out_afr_reg   <= out_afr_next;
        out_found_reg <= out_found_next;
        out_hint_reg  <= out_hint_next;
    end

    // Result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (M_DATA_W - 2 * FRAME_W - ADDRESS_W - 2)'(0),
        out_hint_reg,
        out_found_reg,
        ADDRESS_W'({out_afr_reg, PAGE_SHIFT'(0)}),
        out_afr_reg,
        out_busy_reg
    };

endmodule

// ===== sim/frame_bitmap_allocator_core_test.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_core_test: self-checking bench for the frame allocator
// Drives mark, test, allocate, rescan and unknown requests into the core and
// predicts every result with a behavioural copy of the bitmap, the hint and
// the two configuration registers. A directed part covers the corner cases.
// It is followed by random traffic under four idling patterns and a long
// hold-off on the result stream.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_core_test;
    import fba_pkg::*;

    localparam int NUM_FRAMES       = NUM_FRAMES_DEF;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int DRAIN_CYCLES     = 300;
    localparam int HOLD_CYCLES      = 400;
    localparam int SEGMENT_REQUESTS = 115;
    localparam int REPORT_LIMIT     = 10;

    // The first operation code that the core does not define
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;

    typedef struct packed {
        logic                 frame_busy;
        frame_t               alloc_frame;
        logic [ADDRESS_W-1:0] alloc_address;
        logic                 found;
        frame_t               hint;
    } result_t;

    // Clock, reset and block ports; all that the bench drives are known from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predicted state of the allocator
    logic [NUM_FRAMES-1:0]  frame_in_use = '0;
    frame_t                 free_hint    = '0;
    frame_t                 search_limit = '0;
    logic                   search_on    = 1'b1;
    frame_t                 handed_out[$];
    result_t                pending_results[$];

    // Traffic shaping and bookkeeping
    int send_idle_pct    = 0;
    int stall_pct        = 0;
    int hold_request     = 0;
    int hold_left        = 0;
    int cycle_count      = 0;
    int mismatch_count   = 0;
    int requests_sent    = 0;
    int settings_written = 0;
    int allocations      = 0;
    int empty_searches   = 0;
    result_t got_result;
    result_t want_result;

    always #2 clk = ~clk;

    frame_bitmap_allocator_core #(
        .NUM_FRAMES (NUM_FRAMES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Next-fit search: from the hint to the last frame, then wrap from zero.
    function automatic bit find_next_free();
        int top;
        int origin;
        if (!search_on)
        begin
            return 1'b0;
        end
        top    = int'(search_limit);
        origin = int'(free_hint);
        if (top > NUM_FRAMES - 1)
        begin
            top = NUM_FRAMES - 1;
        end
        for (int f = origin; f <= top; f++)
        begin
            if (!frame_in_use[f])
            begin
                free_hint = frame_t'(f);
                return 1'b1;
            end
        end
        for (int f = 0; f <= origin; f++)
        begin
            if (!frame_in_use[f])
            begin
                free_hint = frame_t'(f);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the predicted state and returns its result.
    function automatic result_t allocator_outcome(input logic [OP_W-1:0] op,
                                                  input frame_t frame);
        result_t r;
        r = '0;
        case (op)
            OP_MARK_USED: frame_in_use[frame] = 1'b1;
            OP_MARK_FREE: frame_in_use[frame] = 1'b0;
            OP_TEST:      r.frame_busy = frame_in_use[frame];
            OP_ALLOC:
            begin
                // The hinted frame is handed out even when already busy.
                r.alloc_frame   = free_hint;
                r.alloc_address = ADDRESS_W'(free_hint) << PAGE_SHIFT;
                frame_in_use[free_hint] = 1'b1;
                handed_out.push_back(free_hint);
                r.found = find_next_free();
                allocations++;
                if (!r.found)
                begin
                    empty_searches++;
                end
            end
            OP_RESCAN:
            begin
                r.found = find_next_free();
                if (!r.found)
                begin
                    empty_searches++;
                end
            end
            default: ;
        endcase
        r.hint = free_hint;
        return r;
    endfunction

    function automatic result_t unpack_result(input logic [M_DATA_W-1:0] d);
        result_t r;
        r.frame_busy    = d[0];
        r.alloc_frame   = d[13:1];
        r.alloc_address = d[38:14];
        r.found         = d[39];
        r.hint          = d[52:40];
        return r;
    endfunction

    // A frame close to the searched range, where the interesting bits live.
    function automatic frame_t nearby_frame();
        int hi;
        hi = int'(search_limit) + 40;
        if (hi > NUM_FRAMES - 1)
        begin
            hi = NUM_FRAMES - 1;
        end
        return frame_t'($urandom_range(0, hi));
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("Result %s differs: expected %0d, got %0d", field, want_v, got_v);
        end
    endtask

    // Offers one request and records its predicted result once accepted.
    task automatic send_request(input logic [OP_W-1:0] op, input frame_t frame);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {frame, op};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(allocator_outcome(op, frame));
        requests_sent++;
    endtask

    // Withdraws the request stream and waits for every outstanding result.
    task automatic wait_until_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register writes only happen with nothing in flight.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_until_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == REG_LAST_FRAME)
        begin
            search_limit = value[FRAME_W-1:0];
        end
        else
        begin
            search_on = value[0];
        end
        settings_written++;
    endtask

    // Reset register values: only frame zero is searched, so it runs full.
    task automatic test_reset_state();
        send_request(OP_TEST, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '1);
        send_request(OP_RESCAN, '0);
    endtask

    // Marking and testing at the top end of the frame range and alternating bits.
    task automatic test_marks_and_tests();
        write_register(REG_LAST_FRAME, CFG_DATA_W'(NUM_FRAMES - 1));
        send_request(OP_MARK_USED, frame_t'(NUM_FRAMES - 1));
        send_request(OP_TEST, frame_t'(NUM_FRAMES - 1));
        send_request(OP_TEST, frame_t'(NUM_FRAMES - 2));
        send_request(OP_MARK_FREE, frame_t'(NUM_FRAMES - 1));
        send_request(OP_TEST, frame_t'(NUM_FRAMES - 1));
        send_request(OP_MARK_USED, 13'h1555);
        send_request(OP_TEST, 13'h1555);
        send_request(OP_TEST, 13'h0AAA);
    endtask

    // Allocation moves the hint past frames that are already busy.
    task automatic test_allocation_cases();
        send_request(OP_RESCAN, '0);
        send_request(OP_MARK_USED, 13'd2);
        send_request(OP_ALLOC, '0);
    endtask

    // Search switched off, then a hint that lies above the last frame.
    task automatic test_search_control();
        write_register(REG_SEARCH_ENABLE, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_RESCAN, '0);
        write_register(REG_SEARCH_ENABLE, CFG_DATA_W'(1));
        write_register(REG_LAST_FRAME, CFG_DATA_W'(2));
        send_request(OP_MARK_FREE, '0);
        send_request(OP_RESCAN, '0);
        send_request(OP_ALLOC, '0);
    endtask

    // Undefined operation codes leave the state alone and report the hint.
    task automatic test_unknown_ops();
        send_request(OP_UNUSED_FIRST, '0);
        send_request(OP_UNUSED_FIRST + 3'd1, '1);
        send_request(OP_UNUSED_FIRST + 3'd2, frame_t'($urandom_range(0, NUM_FRAMES - 1)));
    endtask

    // Random traffic in segments, each under a fresh register setting.
    task automatic test_random_mix(input int send_idle, input int recv_stall);
        int first;
        int choice;
        int pick;
        logic [CFG_DATA_W-1:0] limit;
        send_idle_pct = send_idle;
        stall_pct     = recv_stall;
        repeat (4)
        begin
            case ($urandom_range(0, 5))
                0:       limit = '0;
                1:       limit = CFG_DATA_W'(NUM_FRAMES - 1);
                2:       limit = CFG_DATA_W'($urandom_range(1, 63));
                3:       limit = CFG_DATA_W'($urandom_range(64, 600));
                4:       limit = CFG_DATA_W'($urandom_range(0, NUM_FRAMES - 1));
                default: limit = CFG_DATA_W'(BITS_PER_WORD - 1 + $urandom_range(0, 1));
            endcase
            write_register(REG_LAST_FRAME, limit);
            write_register(REG_SEARCH_ENABLE, CFG_DATA_W'($urandom_range(0, 9) != 0));
            first = requests_sent;
            while (requests_sent - first < SEGMENT_REQUESTS)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 40)
                begin
                    // A burst of allocations, which can fill a small searched range.
                    repeat ($urandom_range(1, 24))
                    begin
                        send_request(OP_ALLOC, frame_t'($urandom_range(0, NUM_FRAMES - 1)));
                    end
                end
                else if (choice < 55)
                begin
                    // Give back frames that were handed out earlier.
                    repeat ($urandom_range(1, 8))
                    begin
                        if (handed_out.size() != 0)
                        begin
                            pick = $urandom_range(0, handed_out.size() - 1);
                            send_request(OP_MARK_FREE, handed_out[pick]);
                            handed_out.delete(pick);
                        end
                        else
                        begin
                            send_request(OP_MARK_FREE, nearby_frame());
                        end
                    end
                end
                else if (choice < 65)
                begin
                    send_request(OP_RESCAN, frame_t'($urandom_range(0, NUM_FRAMES - 1)));
                end
                else if (choice < 75)
                begin
                    send_request(OP_TEST, nearby_frame());
                end
                else if (choice < 85)
                begin
                    send_request(OP_MARK_USED, nearby_frame());
                end
                else
                begin
                    send_request(OP_W'($urandom_range(0, 7)),
                                 frame_t'($urandom_range(0, NUM_FRAMES - 1)));
                end
            end
        end
    endtask

    // The receiver holds off while requests keep coming, so the input stalls.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        wait_until_idle();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
        begin
            send_request((i % 2 != 0) ? OP_TEST : OP_ALLOC,
                         frame_t'($urandom_range(0, NUM_FRAMES - 1)));
        end
    endtask

    // Receiver: random stalls, plus a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
        end
        m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each result with the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = unpack_result(m_tdata);
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("Result arrived with no request outstanding: hint %0d",
                             got_result.hint);
                end
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result.frame_busy !== want_result.frame_busy)
                begin
                    note_mismatch("frame_busy", 32'(want_result.frame_busy),
                                  32'(got_result.frame_busy));
                end
                if (got_result.alloc_frame !== want_result.alloc_frame)
                begin
                    note_mismatch("alloc_frame", 32'(want_result.alloc_frame),
                                  32'(got_result.alloc_frame));
                end
                if (got_result.alloc_address !== want_result.alloc_address)
                begin
                    note_mismatch("alloc_address", 32'(want_result.alloc_address),
                                  32'(got_result.alloc_address));
                end
                if (got_result.found !== want_result.found)
                begin
                    note_mismatch("found", 32'(want_result.found), 32'(got_result.found));
                end
                if (got_result.hint !== want_result.hint)
                begin
                    note_mismatch("hint", 32'(want_result.hint), 32'(got_result.hint));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_marks_and_tests();
        test_allocation_cases();
        test_search_control();
        test_unknown_ops();
        test_random_mix(0, 0);
        test_random_mix(81, 0);
        test_random_mix(0, 81);
        test_random_mix(28, 28);
        test_result_backpressure();

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d register writes over four idling patterns",
                 requests_sent, settings_written);
        $display("and one long result hold-off: %0d allocations, %0d empty searches.",
                 allocations, empty_searches);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
